/* design/sbf_pkg.sv */
// Package for the serial bit framer: shared constants, enum types and the baud mask tables.
// No dependencies; every other design file uses it by scoped names.
package sbf_pkg;

   localparam int DATA_BITS  = 8;
   localparam int DATA_IDX_W = $clog2(DATA_BITS);
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 4;
   localparam int TICK_W     = 8;
   localparam int SEL_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TX_BAUD   = 3'd0,
      CSR_RX_BAUD   = 3'd1,
      CSR_RS423     = 3'd2,
      CSR_MOTOR     = 3'd3,
      CSR_SOURCE_AT = 3'd4,
      CSR_SINK_AT   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_START = 2'd1,
      KIND_DATA  = 2'd2,
      KIND_STOP  = 2'd3
   } tx_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } rx_phase_type;

   typedef struct packed {
      logic tx_en;
      logic rx_en;
   } clk_en_type;

   function automatic logic [TICK_W-1:0] tx_mask(input logic [SEL_W-1:0] sel);
      logic [TICK_W-1:0] m;
      case (sel)
         3'd0:    m = 8'd0;
         3'd1:    m = 8'd0;
         3'd2:    m = 8'd3;
         3'd3:    m = 8'd7;
         3'd4:    m = 8'd15;
         3'd5:    m = 8'd63;
         3'd6:    m = 8'd127;
         default: m = 8'd255;
      endcase
      return m;
   endfunction

   function automatic logic [TICK_W-1:0] rx_mask(input logic [SEL_W-1:0] sel);
      logic [TICK_W-1:0] m;
      case (sel)
         3'd0:    m = 8'd15;
         3'd1:    m = 8'd0;
         3'd2:    m = 8'd3;
         3'd3:    m = 8'd7;
         3'd4:    m = 8'd15;
         3'd5:    m = 8'd63;
         3'd6:    m = 8'd127;
         default: m = 8'd255;
      endcase
      return m;
   endfunction

endpackage

/* design/sbf_baud.sv */
// Baud divider: tick counter that advances with each accepted item, masked per direction to give clock enables.
// Depends on sbf_pkg.
module sbf_baud (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [sbf_pkg::SEL_W-1:0]  tx_baud_select,
   input  logic [sbf_pkg::SEL_W-1:0]  rx_baud_select,
   output sbf_pkg::clk_en_type        clk_en
);

   logic [sbf_pkg::TICK_W-1:0] tick_ff;
   logic [sbf_pkg::TICK_W-1:0] tick_in;

   assign tick_in = tick_ff + sbf_pkg::TICK_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (advance) begin
         tick_ff <= tick_in;
      end
   end

   assign clk_en.tx_en = ((tick_ff & sbf_pkg::tx_mask(tx_baud_select)) == '0);
   assign clk_en.rx_en = ((tick_ff & sbf_pkg::rx_mask(rx_baud_select)) == '0);

endmodule

/* design/sbf_tx.sv */
// Transmit side: assembles start, data and stop bit reports into a byte, LSB first.
// Depends on sbf_pkg.
module sbf_tx (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        tx_en,
   input  sbf_pkg::tx_kind_type        tx_kind,
   input  logic                        tx_bit,
   input  logic                        sink_attached,
   output logic                        byte_valid,
   output logic [sbf_pkg::BYTE_W-1:0]  byte_out
);

   logic [sbf_pkg::BYTE_W-1:0]  shift_ff;
   logic [sbf_pkg::BYTE_W-1:0]  shift_in;
   logic [sbf_pkg::INDEX_W-1:0] index_ff;
   logic [sbf_pkg::INDEX_W-1:0] index_in;
   logic                        stop_hit;

   always_comb begin
      shift_in = shift_ff;
      index_in = index_ff;
      case (tx_kind)
         sbf_pkg::KIND_START: begin
            shift_in = '0;
            index_in = '0;
         end
         sbf_pkg::KIND_DATA: begin
            if (index_ff < sbf_pkg::INDEX_W'(sbf_pkg::DATA_BITS)) begin
               shift_in[index_ff[2:0]] = shift_ff[index_ff[2:0]] | tx_bit;
               index_in = index_ff + sbf_pkg::INDEX_W'(1);
            end
         end
         default: begin
            shift_in = shift_ff;
            index_in = index_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         index_ff <= '0;
      end else if (advance && tx_en) begin
         shift_ff <= shift_in;
         index_ff <= index_in;
      end
   end

   assign stop_hit   = tx_en && (tx_kind == sbf_pkg::KIND_STOP) && sink_attached;
   assign byte_valid = stop_hit;
   assign byte_out   = stop_hit ? shift_ff : '0;

endmodule

/* design/sbf_rx.sv */
// Receive side: serializes source bytes onto the line with an idle, start, data, stop machine.
// Depends on sbf_pkg.
module sbf_rx (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        rx_en,
   input  logic                        source_attached,
   input  logic                        source_has_data,
   input  logic [sbf_pkg::BYTE_W-1:0]  source_byte,
   output logic                        line_bit,
   output logic                        source_take
);

   sbf_pkg::rx_phase_type        phase_ff;
   sbf_pkg::rx_phase_type        phase_in;
   logic [sbf_pkg::BYTE_W-1:0]   hold_ff;
   logic [sbf_pkg::BYTE_W-1:0]   hold_in;
   logic [sbf_pkg::INDEX_W-1:0]  index_ff;
   logic [sbf_pkg::INDEX_W-1:0]  index_in;
   logic [sbf_pkg::INDEX_W-1:0]  index_inc;
   logic                         active;

   assign active    = rx_en && source_attached;
   assign index_inc = index_ff + sbf_pkg::INDEX_W'(1);

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         sbf_pkg::PH_IDLE: begin
            if (source_has_data) begin
               phase_in = sbf_pkg::PH_START;
            end
         end
         sbf_pkg::PH_START: begin
            phase_in = sbf_pkg::PH_DATA;
         end
         sbf_pkg::PH_DATA: begin
            if (index_inc >= sbf_pkg::INDEX_W'(sbf_pkg::DATA_BITS)) begin
               phase_in = sbf_pkg::PH_STOP;
            end
         end
         default: begin
            phase_in = sbf_pkg::PH_IDLE;
         end
      endcase
   end

   always_comb begin
      line_bit    = 1'b1;
      source_take = 1'b0;
      hold_in     = hold_ff;
      index_in    = index_ff;
      if (active) begin
         case (phase_ff)
            sbf_pkg::PH_IDLE: begin
               if (source_has_data) begin
                  hold_in     = source_byte;
                  source_take = 1'b1;
               end
            end
            sbf_pkg::PH_START: begin
               line_bit = 1'b0;
               index_in = '0;
            end
            sbf_pkg::PH_DATA: begin
               line_bit = hold_ff[index_ff[sbf_pkg::DATA_IDX_W-1:0]];
               index_in = index_inc;
            end
            default: begin
               line_bit = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sbf_pkg::PH_IDLE;
         hold_ff  <= '0;
         index_ff <= '0;
      end else if (advance && active) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         index_ff <= index_in;
      end
   end

endmodule

/* design/serial_bit_framer_with_baud_divider_unit.sv */
// Top level of the serial bit framer: config registers, baud divider, tx and rx sides, result register.
// Depends on sbf_pkg, sbf_baud, sbf_tx and sbf_rx.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_tvalid/req_tready  req_tdata, req_tuser (one item per machine tick)
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata (one result per item)
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// Each item's result is in the single result register in the cycle after the item is accepted,
// loaded with the state update. One item can be accepted every cycle while no result is stalled.
// A stalled result holds the result register and stops new items until it is taken.
// Reset clears the tick counter, the tx and rx state and all configuration registers.
module serial_bit_framer_with_baud_divider_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tx_bit [0], source_has_data [1], source_byte [9:2], zero fill [15:10]
   input  logic [sbf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tx_kind [1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tx_clock_enable [0], rx_clock_enable [1], rx_line_bit [2], source_take [3],
   // tx_byte_valid [4], tx_byte [12:5], not_dcd [13], motor_on [14], zero fill [15]
   output logic [sbf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbf_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [sbf_pkg::SEL_W-1:0]       tx_baud_ff;
   logic [sbf_pkg::SEL_W-1:0]       rx_baud_ff;
   logic                            rs423_ff;
   logic                            motor_ff;
   logic                            source_at_ff;
   logic                            sink_at_ff;
   logic                            advance;
   sbf_pkg::clk_en_type             clk_en;
   sbf_pkg::tx_kind_type            tx_kind;
   logic                            byte_valid;
   logic [sbf_pkg::BYTE_W-1:0]      byte_out;
   logic                            line_bit;
   logic                            source_take;
   logic                            rsp_valid_ff;
   logic [sbf_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [sbf_pkg::RSP_DATA_W-1:0]  rsp_data_in;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;
   assign tx_kind    = sbf_pkg::tx_kind_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_baud_ff   <= '0;
         rx_baud_ff   <= '0;
         rs423_ff     <= 1'b0;
         motor_ff     <= 1'b0;
         source_at_ff <= 1'b0;
         sink_at_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (sbf_pkg::csr_index_type'(csr_index))
            sbf_pkg::CSR_TX_BAUD:   tx_baud_ff   <= csr_data;
            sbf_pkg::CSR_RX_BAUD:   rx_baud_ff   <= csr_data;
            sbf_pkg::CSR_RS423:     rs423_ff     <= csr_data[0];
            sbf_pkg::CSR_MOTOR:     motor_ff     <= csr_data[0];
            sbf_pkg::CSR_SOURCE_AT: source_at_ff <= csr_data[0];
            sbf_pkg::CSR_SINK_AT:   sink_at_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   sbf_baud u_baud (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .tx_baud_select (tx_baud_ff),
      .rx_baud_select (rx_baud_ff),
      .clk_en         (clk_en)
   );

   sbf_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .tx_en         (clk_en.tx_en),
      .tx_kind       (tx_kind),
      .tx_bit        (req_tdata[0]),
      .sink_attached (sink_at_ff),
      .byte_valid    (byte_valid),
      .byte_out      (byte_out)
   );

   sbf_rx u_rx (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .rx_en           (clk_en.rx_en),
      .source_attached (source_at_ff),
      .source_has_data (req_tdata[1]),
      .source_byte     (req_tdata[9:2]),
      .line_bit        (line_bit),
      .source_take     (source_take)
   );

   assign rsp_data_in = {1'b0, motor_ff, !rs423_ff, byte_out, byte_valid, source_take,
                         line_bit, clk_en.rx_en, clk_en.tx_en};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/sbf_checker.sv */
// Port-level checker for the serial bit framer top level, attached by a bind statement.
// Depends on serial_bit_framer_with_baud_divider_unit and sbf_pkg.
module sbf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sbf_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result changed or dropped.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled while the result register is empty.");

   a_byte_needs_tx_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[0])
      else $error("Byte delivered on a tick without a transmit clock.");

   a_take_on_rx_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[1] && rsp_tdata[2])
      else $error("Source byte taken without a receive clock or with the line low.");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("Accepted item produced no result.");

endmodule

bind serial_bit_framer_with_baud_divider_unit sbf_checker u_sbf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
